// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the shape containment block.
// No dependencies; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/spsc_pkg.sv =====
// Shared types and constants of the shape containment block.
// No dependencies; used by spsc_mac and the top level.
package spsc_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_WIDTH  = 24;
  localparam int MODE_W           = 2;
  localparam int VIDX_W           = 6;
  localparam int CNT_W            = 7;
  localparam int CFG_IDX_W        = 3;
  localparam int STEP_W           = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_POINT   = 2'd1,
    MODE_SEGMENT = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_IS_CIRCLE = 3'd0,
    CFG_VERTEX_COUNT    = 3'd1,
    CFG_CENTER_X        = 3'd2,
    CFG_CENTER_Y        = 3'd3,
    CFG_RADIUS          = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACC_LOAD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    SHF_NONE     = 2'd0,
    SHF_LIMB     = 2'd1,
    SHF_TWO_LIMB = 2'd2
  } shf_t;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_DEN  = 3'd1,
    DST_NUM1 = 3'd2,
    DST_NUM2 = 3'd3,
    DST_A    = 3'd4,
    DST_HB   = 3'd5,
    DST_C    = 3'd6
  } dest_t;

  typedef enum logic [2:0] {
    PRG_POLY_PT  = 3'd0,
    PRG_POLY_SEG = 3'd1,
    PRG_CIRC_PT  = 3'd2,
    PRG_CIRC_SEG = 3'd3,
    PRG_WIDE     = 3'd4
  } prog_t;

  // What the accumulator does with a product in the cycle after it is issued.
  typedef struct packed {
    logic    vld;
    acc_op_t op;
    shf_t    shf;
    dest_t   dest;
  } mac_tag_t;

  // Index of the last multiply that a program issues.
  function automatic logic [STEP_W-1:0] prog_last(input prog_t p);
    logic [STEP_W-1:0] r;
    unique case (p)
      PRG_POLY_PT:  r = 3'd1;
      PRG_POLY_SEG: r = 3'd5;
      PRG_CIRC_PT:  r = 3'd2;
      PRG_CIRC_SEG: r = 3'd6;
      PRG_WIDE:     r = 3'd7;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/spsc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spsc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/spsc_mac.sv =====
// Shared signed multiplier with a registered product and a wide shifting accumulator.
// Depends on spsc_pkg for the accumulate tag.
module spsc_mac #(
  parameter int MW = 27,
  parameter int LW = 26,
  parameter int AW = 106
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spsc_pkg::mac_tag_t       tag_in,
  input  logic signed [MW-1:0]     op_a,
  input  logic signed [MW-1:0]     op_b,
  output logic signed [AW-1:0]     res,
  output spsc_pkg::mac_tag_t       res_tag,
  output logic signed [AW-1:0]     acc
);
  import spsc_pkg::*;

  logic signed [2*MW-1:0] prod_r;
  mac_tag_t               tag_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;
  logic signed [AW-1:0]   prod_ext;
  logic signed [AW-1:0]   addend;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    if (tag_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod_ext = {{(AW-2*MW){prod_r[2*MW-1]}}, prod_r};

  always_comb begin
    unique case (tag_r.shf)
      SHF_NONE:     addend = prod_ext;
      SHF_LIMB:     addend = prod_ext <<< LW;
      SHF_TWO_LIMB: addend = prod_ext <<< (2*LW);
      default:      addend = prod_ext;
    endcase
    unique case (tag_r.op)
      ACC_LOAD: acc_nxt = addend;
      ACC_ADD:  acc_nxt = acc_r + addend;
      ACC_SUB:  acc_nxt = acc_r - addend;
      default:  acc_nxt = addend;
    endcase
  end

  assign res     = acc_nxt;
  assign res_tag = tag_r;
  assign acc     = acc_r;

endmodule

// ===== rtl/shape_point_segment_containment.sv =====
// Top level of the shape containment block: sequencer, vertex store and result register.
// Depends on spsc_pkg, spsc_ram, spsc_mac and assert_macros.svh.
//
// Usage. The input channel (in_valid / in_stall) carries one item per transfer:
// a vertex load (mode 0), a point query (mode 1) or a segment query (mode 2).
// Each query produces exactly one transfer on the result channel (out_valid /
// out_stall) with out_hit; loads and mode 3 produce none. A load leaves in_stall low.
// A query is worked by one shared signed multiplier and accumulator stepped by
// a small sequencer, and in_stall stays high until the result is registered.
// A polygon query with vertices in use fetches the store, then for each vertex
// steps through prepare, multiply, drain and check states; a circle segment query
// adds the wide product compare when the closest approach has to be checked.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls and a second result is ready, the sequencer holds in
// its result state until the register drains. Reset is synchronous: it clears
// the sequencer, the output valid flag and all configuration registers. The
// vertex store is not cleared.
`include "assert_macros.svh"

module shape_point_segment_containment #(
  parameter int MAX_VERTICES = spsc_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = spsc_pkg::DEF_COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spsc_pkg::MODE_W-1:0]       in_mode,
  input  logic [spsc_pkg::VIDX_W-1:0]       in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]     in_x_a,
  input  logic signed [COORD_WIDTH-1:0]     in_y_a,
  input  logic signed [COORD_WIDTH-1:0]     in_x_b,
  input  logic signed [COORD_WIDTH-1:0]     in_y_b,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  // configuration port
  input  logic                              cfg_we,
  input  logic [spsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata
);
  import spsc_pkg::*;

  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;       // coordinate differences
  localparam int PW   = 2 * DW + 2;  // sums of two products
  localparam int LW   = PW / 2;      // limb of a wide operand
  localparam int MW   = LW + 1;      // multiplier operand
  localparam int AW   = 2 * PW + 2;  // accumulator

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_FETCH_J = 12'b0000_0000_0010,
    S_FETCH_K = 12'b0000_0000_0100,
    S_FETCH_I = 12'b0000_0000_1000,
    S_PREP    = 12'b0000_0001_0000,
    S_MUL     = 12'b0000_0010_0000,
    S_DRAIN   = 12'b0000_0100_0000,
    S_CHECK   = 12'b0000_1000_0000,
    S_CG1     = 12'b0001_0000_0000,
    S_CDEC    = 12'b0010_0000_0000,
    S_FINAL   = 12'b0100_0000_0000,
    S_RES     = 12'b1000_0000_0000
  } state_t;

  function automatic logic signed [MW-1:0] ext_d(input logic signed [DW-1:0] v);
    return {{(MW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] ext_l(input logic [LW-1:0] v);
    return {{(MW-LW){1'b0}}, v};
  endfunction

  function automatic logic signed [DW-1:0] dif(input logic [W-1:0] a, input logic [W-1:0] b);
    return {a[W-1], a} - {b[W-1], b};
  endfunction

  function automatic mac_tag_t mk_tag(input acc_op_t op, input shf_t shf, input dest_t dest);
    mac_tag_t t;
    t.vld  = 1'b1;
    t.op   = op;
    t.shf  = shf;
    t.dest = dest;
    return t;
  endfunction

  // Configuration registers.
  logic                  shape_is_circle_r;
  logic [CNT_W-1:0]      vertex_count_r;
  logic signed [W-1:0]   center_x_r;
  logic signed [W-1:0]   center_y_r;
  logic [W-2:0]          radius_r;

  // Sequencer.
  state_t                state_r, state_nxt;
  prog_t                 prog_r;
  logic [STEP_W-1:0]     k_r;
  logic [IDXW-1:0]       idx_r;
  logic                  last_r;
  logic                  seg_r;
  logic                  inside_r;
  logic                  res_hit_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;

  // Query operands.
  logic signed [W-1:0]   q_x_r, q_y_r;
  logic signed [W-1:0]   pv_x_r, pv_y_r;
  logic signed [DW-1:0]  dx_r, dy_r, fx_r, fy_r;
  logic signed [DW-1:0]  ex_r, ey_r, wx_r, wy_r;
  logic                  cross_r;

  // Results captured from the accumulator and values derived from them.
  logic signed [PW-1:0]  den_r, n1_r, n2_r;
  logic signed [PW-1:0]  a_r, hb_r, c_r, g1_r;
  logic [PW-1:0]         xm_r;

  // Store and multiplier wiring.
  logic                  ram_we;
  logic [31:0]           slot32;
  logic [2*W-1:0]        ram_rdata;
  logic signed [W-1:0]   rd_x, rd_y;
  mac_tag_t              tag_in, res_tag;
  logic signed [MW-1:0]  op_a, op_b;
  logic signed [AW-1:0]  mac_res, acc;

  logic                  in_xfer;
  logic [CNT_W-1:0]      n_use;
  logic [31:0]           nm1_32;
  logic                  slot_free;

  // Edge and circle decisions.
  logic                  den_z, den_pos, ru1, ru2, seg_edge_hit, pt_toggle, inside_nxt;
  logic                  a_z, c_z, g_z, c_le, g_le, hb_pos, ahb_neg;
  logic signed [PW-1:0]  ahb;
  logic                  cdec_done, cdec_hit;
  logic                  final_hit;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign n_use     = (int'(vertex_count_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                          : vertex_count_r;
  assign nm1_32    = 32'(n_use) - 32'd1;
  assign slot32    = 32'(in_vertex_index);
  assign ram_we    = in_xfer && (mode_t'(in_mode) == MODE_LOAD) && (slot32 < MAX_VERTICES);
  assign rd_x      = ram_rdata[2*W-1:W];
  assign rd_y      = ram_rdata[W-1:0];

  spsc_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot32[IDXW-1:0]),
    .wdata ({in_x_a, in_y_a}),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  spsc_mac #(
    .MW (MW),
    .LW (LW),
    .AW (AW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag_in),
    .op_a    (op_a),
    .op_b    (op_b),
    .res     (mac_res),
    .res_tag (res_tag),
    .acc     (acc)
  );

  // Multiply schedule: each step names two operands and what the accumulator
  // does with their product on the following cycle.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    tag_in = '0;
    if (state_r == S_MUL) begin
      unique case (prog_r)
        PRG_POLY_PT: begin
          unique case (k_r)
            3'd0: begin op_a = ext_d(wx_r); op_b = ext_d(ey_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd1: begin op_a = ext_d(ex_r); op_b = ext_d(wy_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_NUM1); end
            default: ;
          endcase
        end
        PRG_POLY_SEG: begin
          unique case (k_r)
            3'd0: begin op_a = ext_d(dx_r); op_b = ext_d(ey_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd1: begin op_a = ext_d(dy_r); op_b = ext_d(ex_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_DEN); end
            3'd2: begin op_a = ext_d(ex_r); op_b = ext_d(wy_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd3: begin op_a = ext_d(ey_r); op_b = ext_d(wx_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_NUM1); end
            3'd4: begin op_a = ext_d(dx_r); op_b = ext_d(wy_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd5: begin op_a = ext_d(dy_r); op_b = ext_d(wx_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_NUM2); end
            default: ;
          endcase
        end
        PRG_CIRC_PT: begin
          unique case (k_r)
            3'd0: begin op_a = ext_d(fx_r); op_b = ext_d(fx_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd1: begin op_a = ext_d(fy_r); op_b = ext_d(fy_r);
                        tag_in = mk_tag(ACC_ADD, SHF_NONE, DST_NONE); end
            3'd2: begin op_a = MW'(radius_r); op_b = MW'(radius_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_C); end
            default: ;
          endcase
        end
        PRG_CIRC_SEG: begin
          unique case (k_r)
            3'd0: begin op_a = ext_d(dx_r); op_b = ext_d(dx_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd1: begin op_a = ext_d(dy_r); op_b = ext_d(dy_r);
                        tag_in = mk_tag(ACC_ADD, SHF_NONE, DST_A); end
            3'd2: begin op_a = ext_d(fx_r); op_b = ext_d(dx_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd3: begin op_a = ext_d(fy_r); op_b = ext_d(dy_r);
                        tag_in = mk_tag(ACC_ADD, SHF_NONE, DST_HB); end
            3'd4: begin op_a = ext_d(fx_r); op_b = ext_d(fx_r);
                        tag_in = mk_tag(ACC_LOAD, SHF_NONE, DST_NONE); end
            3'd5: begin op_a = ext_d(fy_r); op_b = ext_d(fy_r);
                        tag_in = mk_tag(ACC_ADD, SHF_NONE, DST_NONE); end
            3'd6: begin op_a = MW'(radius_r); op_b = MW'(radius_r);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_C); end
            default: ;
          endcase
        end
        PRG_WIDE: begin
          // hb*hb - a*c from 26-bit style limbs; all three operands are
          // non-negative here, so the limbs are plain unsigned digits.
          unique case (k_r)
            3'd0: begin op_a = ext_l(xm_r[PW-1:LW]); op_b = ext_l(xm_r[PW-1:LW]);
                        tag_in = mk_tag(ACC_LOAD, SHF_TWO_LIMB, DST_NONE); end
            3'd1: begin op_a = ext_l(xm_r[PW-1:LW]); op_b = ext_l(xm_r[LW-1:0]);
                        tag_in = mk_tag(ACC_ADD, SHF_LIMB, DST_NONE); end
            3'd2: begin op_a = ext_l(xm_r[LW-1:0]); op_b = ext_l(xm_r[PW-1:LW]);
                        tag_in = mk_tag(ACC_ADD, SHF_LIMB, DST_NONE); end
            3'd3: begin op_a = ext_l(xm_r[LW-1:0]); op_b = ext_l(xm_r[LW-1:0]);
                        tag_in = mk_tag(ACC_ADD, SHF_NONE, DST_NONE); end
            3'd4: begin op_a = ext_l(a_r[PW-1:LW]); op_b = ext_l(c_r[PW-1:LW]);
                        tag_in = mk_tag(ACC_SUB, SHF_TWO_LIMB, DST_NONE); end
            3'd5: begin op_a = ext_l(a_r[PW-1:LW]); op_b = ext_l(c_r[LW-1:0]);
                        tag_in = mk_tag(ACC_SUB, SHF_LIMB, DST_NONE); end
            3'd6: begin op_a = ext_l(a_r[LW-1:0]); op_b = ext_l(c_r[PW-1:LW]);
                        tag_in = mk_tag(ACC_SUB, SHF_LIMB, DST_NONE); end
            3'd7: begin op_a = ext_l(a_r[LW-1:0]); op_b = ext_l(c_r[LW-1:0]);
                        tag_in = mk_tag(ACC_SUB, SHF_NONE, DST_NONE); end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Polygon edge decision. The segment test checks both parameters against
  // 0..1 by comparing numerators with the shared denominator in its sign.
  always_comb begin
    den_z        = (den_r == '0);
    den_pos      = !den_r[PW-1] && !den_z;
    ru1          = den_pos ? (!n1_r[PW-1] && (n1_r <= den_r))
                           : ((n1_r[PW-1] || n1_r == '0) && (n1_r >= den_r));
    ru2          = den_pos ? (!n2_r[PW-1] && (n2_r <= den_r))
                           : ((n2_r[PW-1] || n2_r == '0) && (n2_r >= den_r));
    seg_edge_hit = den_z ? ((n1_r == '0) && (n2_r == '0)) : (ru1 && ru2);
    pt_toggle    = cross_r && (ey_r[DW-1] ? (!n1_r[PW-1] && n1_r != '0) : n1_r[PW-1]);
    inside_nxt   = seg_r ? (inside_r || seg_edge_hit) : (inside_r ^ pt_toggle);
  end

  // Circle segment decision from the end values of the quadratic.
  always_comb begin
    a_z       = (a_r == '0);
    c_z       = (c_r == '0);
    g_z       = (g1_r == '0);
    c_le      = c_r[PW-1] || c_z;
    g_le      = g1_r[PW-1] || g_z;
    hb_pos    = !hb_r[PW-1] && (hb_r != '0);
    ahb       = a_r + hb_r;
    ahb_neg   = ahb[PW-1];
    cdec_done = 1'b1;
    cdec_hit  = 1'b0;
    priority if (a_z) begin
      cdec_hit = 1'b0;
    end else if (c_le && g_le) begin
      cdec_hit = c_z || g_z;
    end else if (c_le || g_le) begin
      cdec_hit = 1'b1;
    end else if (hb_pos || ahb_neg) begin
      cdec_hit = 1'b0;
    end else begin
      cdec_done = 1'b0;
    end
    final_hit = (prog_r == PRG_CIRC_PT) ? (c_r[PW-1] || c_z) : !acc[AW-1];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (mode_t'(in_mode) == MODE_POINT || mode_t'(in_mode) == MODE_SEGMENT)) begin
          if (shape_is_circle_r) begin
            state_nxt = S_MUL;
          end else if (n_use == '0) begin
            state_nxt = S_RES;
          end else begin
            state_nxt = S_FETCH_J;
          end
        end
      end
      S_FETCH_J: state_nxt = S_FETCH_K;
      S_FETCH_K: state_nxt = S_FETCH_I;
      S_FETCH_I: state_nxt = S_PREP;
      S_PREP:    state_nxt = S_MUL;
      S_MUL: begin
        if (k_r == prog_last(prog_r)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        unique case (prog_r)
          PRG_POLY_PT, PRG_POLY_SEG: state_nxt = S_CHECK;
          PRG_CIRC_SEG:              state_nxt = S_CG1;
          default:                   state_nxt = S_FINAL;
        endcase
      end
      S_CHECK:  state_nxt = last_r ? S_RES : S_PREP;
      S_CG1:    state_nxt = S_CDEC;
      S_CDEC:   state_nxt = cdec_done ? S_RES : S_MUL;
      S_FINAL:  state_nxt = S_RES;
      S_RES: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_RES && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      shape_is_circle_r <= 1'b0;
      vertex_count_r    <= '0;
      center_x_r        <= '0;
      center_y_r        <= '0;
      radius_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SHAPE_IS_CIRCLE: shape_is_circle_r <= cfg_wdata[0];
          CFG_VERTEX_COUNT:    vertex_count_r    <= cfg_wdata[CNT_W-1:0];
          CFG_CENTER_X:        center_x_r        <= cfg_wdata;
          CFG_CENTER_Y:        center_y_r        <= cfg_wdata;
          CFG_RADIUS:          radius_r          <= cfg_wdata[W-2:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        q_x_r    <= in_x_a;
        q_y_r    <= in_y_a;
        dx_r     <= dif(in_x_b, in_x_a);
        dy_r     <= dif(in_y_b, in_y_a);
        fx_r     <= dif(in_x_a, center_x_r);
        fy_r     <= dif(in_y_a, center_y_r);
        seg_r    <= (mode_t'(in_mode) == MODE_SEGMENT);
        inside_r <= 1'b0;
        idx_r    <= nm1_32[IDXW-1:0];
        k_r      <= '0;
        prog_r   <= (mode_t'(in_mode) == MODE_SEGMENT) ? PRG_CIRC_SEG : PRG_CIRC_PT;
        res_hit_r <= 1'b0;
      end
      S_FETCH_K: begin
        pv_x_r <= rd_x;
        pv_y_r <= rd_y;
        idx_r  <= '0;
      end
      S_PREP: begin
        ex_r    <= dif(pv_x_r, rd_x);
        ey_r    <= dif(pv_y_r, rd_y);
        wx_r    <= dif(q_x_r, rd_x);
        wy_r    <= dif(q_y_r, rd_y);
        cross_r <= (rd_y > q_y_r) != (pv_y_r > q_y_r);
        pv_x_r  <= rd_x;
        pv_y_r  <= rd_y;
        last_r  <= (32'(idx_r) == nm1_32);
        idx_r   <= idx_r + 1'b1;
        prog_r  <= seg_r ? PRG_POLY_SEG : PRG_POLY_PT;
        k_r     <= '0;
      end
      S_MUL:   k_r <= k_r + 1'b1;
      S_CHECK: begin
        inside_r  <= inside_nxt;
        res_hit_r <= inside_nxt;
      end
      S_CG1:   g1_r <= a_r + c_r + (hb_r <<< 1);
      S_CDEC: begin
        res_hit_r <= cdec_hit;
        xm_r      <= -hb_r;
        prog_r    <= PRG_WIDE;
        k_r       <= '0;
      end
      S_FINAL: res_hit_r <= final_hit;
      default: ;
    endcase

    if (res_tag.vld) begin
      unique case (res_tag.dest)
        DST_DEN:  den_r <= mac_res[PW-1:0];
        DST_NUM1: n1_r  <= mac_res[PW-1:0];
        DST_NUM2: n2_r  <= mac_res[PW-1:0];
        DST_A:    a_r   <= mac_res[PW-1:0];
        DST_HB:   hb_r  <= mac_res[PW-1:0];
        DST_C:    c_r   <= mac_res[PW-1:0];
        default: ;
      endcase
    end

    if (state_r == S_RES && slot_free) begin
      out_hit_r <= res_hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // A product reaches the accumulator only while a multiply program runs.
  `ASSERT_IMPLIES(a_tag_in_program, res_tag.vld, (state_r == S_MUL || state_r == S_DRAIN),
    "accumulate outside a multiply program")
  // A new result appears only out of the result state.
  `ASSERT_IMPLIES(a_result_source, $rose(out_valid_r), $past(state_r == S_RES),
    "result raised outside the result state")
  // The step counter never runs past the end of its program.
  `ASSERT_IMPLIES(a_step_bound, state_r == S_MUL, k_r <= prog_last(prog_r),
    "multiply step beyond program end")

endmodule

// ===== tb/shape_point_segment_containment_test.sv =====
// Self-checking testbench of shape_point_segment_containment: polygon and circle
// point/segment queries against an exact integer predictor. Depends on spsc_pkg and the RTL.
`timescale 1ns / 1ps

module shape_point_segment_containment_test;
  import spsc_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int NV = DEF_MAX_VERTICES;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 40000;
  localparam logic signed [CW-1:0] C_MAX = 24'sh7fffff;
  localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [MODE_W-1:0]    mode;
    logic [VIDX_W-1:0]    idx;
    logic signed [CW-1:0] xa, ya, xb, yb;
  } query_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [VIDX_W-1:0] in_vertex_index = '0;
  logic signed [CW-1:0] in_x_a = '0, in_y_a = '0, in_x_b = '0, in_y_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  shape_point_segment_containment u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_vertex_index,
    .in_x_a, .in_y_a, .in_x_b, .in_y_b,
    .out_valid, .out_stall, .out_hit,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: its own copy of the vertex store and the registers.
  longint vert_x[NV], vert_y[NV];
  bit     circle_mode;
  int     vcount;
  longint circ_cx, circ_cy, circ_r;

  query_item_t pending_items[$];
  bit          expected_hits[$];
  query_item_t on_bus;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          failures = 0;
  int          quiet_cycles = 0;

  // Vertices as planned by the stimulus, used to build collinear segments.
  longint plan_x[NV], plan_y[NV];

  function automatic wide_t wx(longint v);
    return wide_t'(v);
  endfunction

  function automatic int sgn(wide_t v);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  function automatic wide_t cross2(longint ax, longint ay, longint bx, longint by);
    return wx(ax) * wx(by) - wx(ay) * wx(bx);
  endfunction

  function automatic int used_count();
    return (vcount > NV) ? NV : vcount;
  endfunction

  // Does num/den lie in 0..1 for a nonzero den, without dividing.
  function automatic bit ratio_in_unit(wide_t num, wide_t den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic bit predict_point(longint px, longint py);
    int n;
    int j;
    bit in_poly;
    longint dy;
    wide_t lhs, rhs;
    n = used_count();
    in_poly = 0;
    if (circle_mode)
      return wx(px - circ_cx) * wx(px - circ_cx) + wx(py - circ_cy) * wx(py - circ_cy)
             <= wx(circ_r) * wx(circ_r);
    if (n == 0) return 0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((vert_y[i] > py) != (vert_y[j] > py)) begin
        dy  = vert_y[j] - vert_y[i];
        lhs = wx(px - vert_x[i]) * wx(dy);
        rhs = wx(vert_x[j] - vert_x[i]) * wx(py - vert_y[i]);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) in_poly = !in_poly;
      end
      j = i;
    end
    return in_poly;
  endfunction

  function automatic bit predict_segment(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy, fx, fy, ex, ey, qx, qy;
    wide_t a, hb, c, g1, den, num1, num2;
    int s0, s1, n, j;
    dx = x2 - x1;
    dy = y2 - y1;
    if (circle_mode) begin
      fx = x1 - circ_cx;
      fy = y1 - circ_cy;
      a  = wx(dx) * wx(dx) + wx(dy) * wx(dy);
      hb = wx(fx) * wx(dx) + wx(fy) * wx(dy);
      c  = wx(fx) * wx(fx) + wx(fy) * wx(fy) - wx(circ_r) * wx(circ_r);
      g1 = a + c + hb + hb;
      // A zero-length segment never meets the circle.
      if (a == 0) return 0;
      s0 = sgn(c);
      s1 = sgn(g1);
      if (s0 <= 0 && s1 <= 0) return s0 == 0 || s1 == 0;
      if (s0 <= 0 || s1 <= 0) return 1;
      // Both ends outside: the closest approach must fall on the segment.
      if (hb > 0 || -hb > a) return 0;
      return hb * hb >= a * c;
    end
    n = used_count();
    if (n == 0) return 0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      ex   = vert_x[j] - vert_x[i];
      ey   = vert_y[j] - vert_y[i];
      qx   = x1 - vert_x[i];
      qy   = y1 - vert_y[i];
      den  = cross2(dx, dy, ex, ey);
      num1 = cross2(ex, ey, qx, qy);
      num2 = cross2(dx, dy, qx, qy);
      if (den == 0) begin
        // Collinear edges count as a hit; merely parallel ones do not.
        if (num1 == 0 && num2 == 0) return 1;
      end else if (ratio_in_unit(num1, den) && ratio_in_unit(num2, den)) begin
        return 1;
      end
      j = i;
    end
    return 0;
  endfunction

  // Applies one accepted transfer to the predictor.
  function automatic void apply_transfer(query_item_t it);
    case (it.mode)
      MODE_LOAD: begin
        vert_x[it.idx] = it.xa;
        vert_y[it.idx] = it.ya;
      end
      MODE_POINT:   expected_hits.push_back(predict_point(it.xa, it.ya));
      MODE_SEGMENT: expected_hits.push_back(predict_segment(it.xa, it.ya, it.xb, it.yb));
      default: ;
    endcase
  endfunction

  // Input driver: holds a stalled payload, takes the next pending item otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_transfer(on_bus);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= on_bus.mode;
          in_vertex_index <= on_bus.idx;
          in_x_a          <= on_bus.xa;
          in_y_a          <= on_bus.ya;
          in_x_b          <= on_bus.xb;
          in_y_b          <= on_bus.yb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: result with no query pending, actual hit=%0b", $realtime, out_hit);
        failures++;
      end else begin
        want = expected_hits.pop_front();
        if (out_hit !== want) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $realtime, want, out_hit);
          failures++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: only cycles with work outstanding and no transfer count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_items.size() == 0 && !in_valid && expected_hits.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** shape_point_segment_containment: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHAPE_IS_CIRCLE: circle_mode = val[0];
      CFG_VERTEX_COUNT:    vcount = val[CNT_W-1:0];
      CFG_CENTER_X:        circ_cx = longint'(signed'(val));
      CFG_CENTER_Y:        circ_cy = longint'(signed'(val));
      CFG_RADIUS:          circ_r = val[CW-2:0];
      default: ;
    endcase
  endtask

  // Waits until every item is taken and every result has arrived, then lets
  // the block settle before the registers change.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly values near base, sometimes anything, sometimes an extreme.
  function automatic logic signed [CW-1:0] pick_coord(longint base, int span);
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return CW'($urandom);
    if (sel == 1) begin
      case ($urandom_range(3))
        0: return C_MAX;
        1: return C_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return CW'(base + longint'($urandom_range(2 * span)) - span);
  endfunction

  function automatic query_item_t make_item(logic [MODE_W-1:0] m, longint ax, longint ay,
                                            longint bx, longint by, int slot);
    query_item_t it;
    it.mode = m;
    it.idx  = VIDX_W'(slot);
    it.xa   = CW'(ax);
    it.ya   = CW'(ay);
    it.xb   = CW'(bx);
    it.yb   = CW'(by);
    return it;
  endfunction

  task automatic queue_load(int slot, longint x, longint y);
    plan_x[slot] = x;
    plan_y[slot] = y;
    pending_items.push_back(make_item(MODE_LOAD, x, y, $urandom, $urandom, slot));
  endtask

  // Random traffic of one phase; bx, by is the shape's rough center.
  task automatic queue_traffic(int count, longint bx, longint by, int span);
    int n, sel, i, j, k1, k2;
    longint ex, ey, x1, y1, ox, oy;
    n = used_count();
    for (int q = 0; q < count; q++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        queue_load($urandom_range(NV - 1), pick_coord(bx, span), pick_coord(by, span));
      end else if (sel < 10) begin
        pending_items.push_back(make_item(MODE_UNUSED, $urandom, $urandom, $urandom,
                                          $urandom, $urandom_range(NV - 1)));
      end else if (sel < 50) begin
        pending_items.push_back(make_item(MODE_POINT, pick_coord(bx, span),
                                          pick_coord(by, span), $urandom, $urandom, 0));
      end else if (sel < 72 && n > 0 && !circle_mode) begin
        // Segment on the line of an edge, with or without overlap, possibly shifted
        // sideways so that it is only parallel.
        i  = $urandom_range(n - 1);
        j  = (i == 0) ? n - 1 : i - 1;
        ex = plan_x[j] - plan_x[i];
        ey = plan_y[j] - plan_y[i];
        k1 = $urandom_range(6) - 3;
        k2 = $urandom_range(6) - 3;
        ox = $urandom_range(2) ? 0 : $urandom_range(40) - 20;
        oy = $urandom_range(2) ? 0 : $urandom_range(40) - 20;
        pending_items.push_back(make_item(MODE_SEGMENT, plan_x[i] + k1 * ex + ox,
                                          plan_y[i] + k1 * ey + oy, plan_x[i] + k2 * ex + ox,
                                          plan_y[i] + k2 * ey + oy, 0));
      end else if (sel < 78) begin
        x1 = pick_coord(bx, span);
        y1 = pick_coord(by, span);
        pending_items.push_back(make_item(MODE_SEGMENT, x1, y1, x1, y1, 0));
      end else begin
        pending_items.push_back(make_item(MODE_SEGMENT, pick_coord(bx, span),
                                          pick_coord(by, span), pick_coord(bx, span),
                                          pick_coord(by, span), 0));
      end
    end
  endtask

  int     counts[12] = '{4, 3, 0, 1, 2, 64, 127, 5, 0, 8, 100, 0};
  int     span, n_items;
  longint cx, cy;
  logic [CW-2:0] rad;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    circle_mode = 0;
    vcount = 0;
    circ_cx = 0;
    circ_cy = 0;
    circ_r = 0;

    // Fill the whole store first so that any vertex count reads written slots.
    for (int s = 0; s < NV; s++)
      queue_load(s, $urandom_range(6000) - 3000, $urandom_range(6000) - 3000);
    queue_load(NV - 1, C_MAX, C_MIN);
    queue_load(NV - 2, C_MIN, C_MAX);
    drain();

    // Directed part: a square polygon with extremes and the unused mode, then an extreme circle.
    write_reg(CFG_VERTEX_COUNT, 4);
    queue_load(0, -1000, -1000);
    queue_load(1, 1000, -1000);
    queue_load(2, 1000, 1000);
    queue_load(3, -1000, 1000);
    pending_items.push_back(make_item(MODE_POINT, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_POINT, 2000, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_POINT, C_MAX, C_MIN, 0, 0, 0));
    pending_items.push_back(make_item(MODE_POINT, C_MIN, C_MAX, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, -3000, 0, 3000, 0, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, -3000, -1000, -2000, -1000, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, -3000, -1500, 3000, -1500, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, C_MIN, C_MIN, C_MAX, C_MAX, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, C_MAX, C_MAX, C_MIN, C_MIN, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, 5000, 5000, 5000, 5000, 0));
    pending_items.push_back(make_item(MODE_UNUSED, 1, 2, 3, 4, 5));
    drain();
    write_reg(CFG_SHAPE_IS_CIRCLE, 1);
    write_reg(CFG_CENTER_X, C_MAX);
    write_reg(CFG_CENTER_Y, C_MIN);
    write_reg(CFG_RADIUS, {(CW - 1){1'b1}});
    pending_items.push_back(make_item(MODE_POINT, C_MIN, C_MAX, 0, 0, 0));
    pending_items.push_back(make_item(MODE_POINT, C_MAX, C_MIN, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, C_MIN, C_MAX, C_MAX, C_MIN, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SEGMENT, C_MIN, C_MIN, C_MIN, C_MAX, 0));
    drain();

    // Random phases: polygon phases with many vertex counts, circle phases
    // with zero, extreme and ordinary radii. Idling changes every four phases.
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 37 : ((ph < 8) ? 61 : 0);
      recv_idle_pct = (ph < 4) ? 61 : ((ph < 8) ? 37 : 0);
      span = 2000;
      cx = $urandom_range(8000) - 4000;
      cy = $urandom_range(8000) - 4000;
      rad = $urandom_range(3000);
      if (ph == 2) rad = '0;
      if (ph == 11) begin
        cx = C_MIN;
        cy = C_MAX;
        rad = '1;
        span = 4000000;
      end
      write_reg(CFG_SHAPE_IS_CIRCLE, (ph % 3 == 2));
      write_reg(CFG_VERTEX_COUNT, counts[ph]);
      write_reg(CFG_CENTER_X, cx);
      write_reg(CFG_CENTER_Y, cy);
      write_reg(CFG_RADIUS, rad);
      if (!circle_mode && used_count() > 0 && used_count() < 16)
        for (int s = 0; s < used_count(); s++)
          queue_load(s, cx + $urandom_range(2 * span) - span,
                     cy + $urandom_range(2 * span) - span);
      n_items = (!circle_mode && used_count() >= 16) ? 40 : 150;
      queue_traffic(n_items, cx, cy, (circle_mode && ph != 11) ? rad + 500 : span);
      drain();
    end

    if (failures == 0) begin
      $display("** shape_point_segment_containment: PASSED **");
    end else begin
      $display("** shape_point_segment_containment: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spsc_pkg.sv
rtl/spsc_ram.sv
rtl/spsc_mac.sv
rtl/shape_point_segment_containment.sv
tb/shape_point_segment_containment_test.sv
